// ===== sv/bts_pkg.sv =====
// Shared types and constants for the buffer timestamp recovery block.
package bts_pkg;

  // Default sizes
  localparam int GROUP_COUNT_BITS_DEF = 16;
  localparam int TIME_BITS_DEF        = 64;

  // Fixed port field widths
  localparam int LEN_W   = 30;
  localparam int TIME_W  = 64;
  localparam int PEND_W  = 16;
  localparam int CODE_W  = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = 30'd11609977;

  // Arrival classification
  typedef enum logic [CODE_W-1:0] {
    CASE_NORMAL  = 3'd0,
    CASE_GROUPED = 3'd1,
    CASE_FIRST   = 3'd2,
    CASE_DELAYED = 3'd3,
    CASE_AFTER   = 3'd4
  } case_code_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLASSIFY,
    ST_MUL,
    ST_START,
    ST_FINISH
  } bts_state_t;

endpackage

// ===== sv/buffer_timestamp_recovery.sv =====
// Buffer timestamp recovery: start/end time assignment for bursty buffer arrivals.
// An accepted arrival word passes through the bit-serial restoring divider, then the
//   classify, multiply, start and end steps; the end step waits while the output
//   register is full and not taken. The input stays not ready until the result is
//   loaded into the output register; a start word leaves the input ready.
// Reset (rst_n low, synchronous): times and group state clear, buffer length returns
//   to 11609977 ns, output register empties.
module buffer_timestamp_recovery #(
  parameter int GROUP_COUNT_BITS = bts_pkg::GROUP_COUNT_BITS_DEF,
  parameter int TIME_BITS        = bts_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration: buffer length in ns
  input  logic                      cfg_we,
  input  logic [bts_pkg::LEN_W-1:0] cfg_wdata,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,   // [63:0] now_time
  input  logic [0:0]                in_tuser,   // [0] req_type
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [143:0]              out_tdata,  // [63:0] buffer_start_time,
                                                // [127:64] buffer_end_time,
                                                // [143:128] pending_in_group
  output logic [2:0]                out_tuser   // [2:0] case_code
);
  import bts_pkg::*;

  localparam int CNT_W = $clog2(TIME_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_BITS - 1);
  localparam int PROD_W = GROUP_COUNT_BITS + LEN_W;

  bts_state_t state_r, state_nxt;

  logic [LEN_W-1:0]            len_r;
  logic [TIME_BITS-1:0]        last_arrival_r, last_end_r, now_r;
  logic [GROUP_COUNT_BITS-1:0] grp_r;
  logic                        lwg_r;

  // divider
  logic [TIME_BITS-1:0]        dvd_r;
  logic [LEN_W-1:0]            rem_r, rem_nxt;
  logic [GROUP_COUNT_BITS-1:0] quo_r;
  logic                        qovf_r;
  logic [CNT_W-1:0]            cnt_r;

  // per-item working registers
  logic [GROUP_COUNT_BITS-1:0] ratio_r, ratio_nxt;
  case_code_t                  code_r, code_nxt;
  logic [TIME_BITS-1:0]        prod_r, start_r, start_nxt, end_nxt;
  logic [PROD_W-1:0]           prod_full;
  logic [GROUP_COUNT_BITS-1:0] mul_op;

  // output register
  logic                        out_valid_r;
  logic [143:0]                out_data_r;
  logic [2:0]                  out_user_r;

  logic                        in_acc, fin_load;
  logic [LEN_W-1:0]            len_eff;
  logic [TIME_BITS-1:0]        len_t;
  logic [LEN_W:0]              trial, trial_diff;
  logic                        fits, round_up;
  logic [TIME_BITS-1:0]        sum_t, diff_t;

  assign in_acc  = in_tvalid && in_tready;
  assign len_eff = (len_r == '0) ? LEN_W'(1) : len_r;
  assign len_t   = TIME_BITS'(len_eff);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_acc && in_tuser[0]) state_nxt = ST_DIV;
      ST_DIV:      if (cnt_r == '0) state_nxt = ST_CLASSIFY;
      ST_CLASSIFY: state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_START;
      ST_START:    state_nxt = ST_FINISH;
      ST_FINISH:   if (fin_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    fin_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_FINISH: fin_load  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // one restoring divide step
  always_comb begin
    trial      = {rem_r, dvd_r[TIME_BITS-1]};
    fits       = trial >= {1'b0, len_eff};
    trial_diff = trial - {1'b0, len_eff};
    rem_nxt    = fits ? trial_diff[LEN_W-1:0] : trial[LEN_W-1:0];
  end

  // rounding, saturation and classification
  always_comb begin
    round_up = {rem_r, 1'b0} >= {1'b0, len_eff};
    if (qovf_r) begin
      ratio_nxt = '1;
    end else if (round_up && !(&quo_r)) begin
      ratio_nxt = quo_r + GROUP_COUNT_BITS'(1);
    end else begin
      ratio_nxt = quo_r;
    end
    if (ratio_nxt == GROUP_COUNT_BITS'(1)) begin
      code_nxt = CASE_NORMAL;
    end else if (ratio_nxt == '0) begin
      code_nxt = (grp_r != '0) ? CASE_GROUPED : CASE_AFTER;
    end else begin
      code_nxt = (grp_r == '0 || lwg_r) ? CASE_FIRST : CASE_DELAYED;
    end
  end

  // count times buffer length
  assign mul_op    = (code_r == CASE_GROUPED) ? grp_r : ratio_r;
  assign prod_full = mul_op * len_eff;

  // start time
  always_comb begin
    diff_t = now_r - len_t;
    case (code_r)
      CASE_NORMAL:                start_nxt = last_arrival_r;
      CASE_GROUPED, CASE_FIRST:   start_nxt = now_r - prod_r;
      CASE_DELAYED:               start_nxt = last_end_r + len_t;
      default:                    start_nxt = (diff_t < last_end_r) ? last_end_r : diff_t;
    endcase
  end

  // end time, clamped to now for grouped and delayed arrivals
  always_comb begin
    sum_t = start_r + len_t;
    case (code_r)
      CASE_FIRST:                 end_nxt = sum_t;
      CASE_GROUPED, CASE_DELAYED: end_nxt = (sum_t > now_r) ? now_r : sum_t;
      default:                    end_nxt = now_r;
    endcase
  end

  // group count as it stands after this arrival
  function automatic logic [GROUP_COUNT_BITS-1:0] grp_after();
    logic [GROUP_COUNT_BITS-1:0] g;
    g = grp_r;
    case (code_r)
      CASE_GROUPED, CASE_DELAYED: g = grp_r - GROUP_COUNT_BITS'(1);
      CASE_FIRST:                 g = ratio_r - GROUP_COUNT_BITS'(1);
      default: ;
    endcase
    return g;
  endfunction

  // control and time state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      len_r          <= LEN_RESET;
      last_arrival_r <= '0;
      last_end_r     <= '0;
      grp_r          <= '0;
      lwg_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) len_r <= cfg_wdata;
      if (in_acc && !in_tuser[0]) begin
        last_arrival_r <= in_tdata[TIME_BITS-1:0];
        last_end_r     <= in_tdata[TIME_BITS-1:0];
        grp_r          <= '0;
        lwg_r          <= 1'b0;
      end
      if (fin_load) begin
        last_arrival_r <= now_r;
        last_end_r     <= end_nxt;
        case (code_r)
          CASE_GROUPED: begin
            grp_r <= grp_r - GROUP_COUNT_BITS'(1);
            lwg_r <= 1'b1;
          end
          CASE_FIRST: begin
            grp_r <= ratio_r - GROUP_COUNT_BITS'(1);
            lwg_r <= 1'b0;
          end
          CASE_DELAYED: grp_r <= grp_r - GROUP_COUNT_BITS'(1);
          CASE_AFTER:   lwg_r <= 1'b0;
          default: ;
        endcase
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r  <= in_tdata[TIME_BITS-1:0];
      dvd_r  <= in_tdata[TIME_BITS-1:0] - last_arrival_r;
      rem_r  <= '0;
      quo_r  <= '0;
      qovf_r <= 1'b0;
      cnt_r  <= CNT_LAST;
    end
    if (state_r == ST_DIV) begin
      dvd_r  <= {dvd_r[TIME_BITS-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[GROUP_COUNT_BITS-2:0], fits};
      qovf_r <= qovf_r | quo_r[GROUP_COUNT_BITS-1];
      cnt_r  <= cnt_r - CNT_W'(1);
    end
    if (state_r == ST_CLASSIFY) begin
      ratio_r <= ratio_nxt;
      code_r  <= code_nxt;
    end
    if (state_r == ST_MUL) prod_r <= TIME_BITS'(prod_full);
    if (state_r == ST_START) start_r <= start_nxt;
    if (fin_load) begin
      out_data_r <= {PEND_W'(grp_after()), TIME_W'(end_nxt), TIME_W'(start_r)};
      out_user_r <= code_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== sv/bts_checker.sv =====
// Port-level checks for the buffer timestamp recovery block, bound to its top level.
module bts_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [0:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic [2:0]   out_tuser
);
  import bts_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // case code stays within the five defined cases
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= CASE_AFTER)
    else $error("case code out of range");

  // the input is ready again in the cycle after a start word
  a_start_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> in_tready)
    else $error("not ready after start word");

  // an arrival word keeps the input busy while it divides
  a_arrival_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !in_tready ##1 !in_tready)
    else $error("input ready during arrival processing");

endmodule

bind buffer_timestamp_recovery bts_checker u_bts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/buffer_timestamp_recovery_tb.sv =====
// Self-checking testbench for buffer_timestamp_recovery: stream driver, monitor, timestamp predictor.
module buffer_timestamp_recovery_tb;
  import bts_pkg::*;

  localparam bit REQ_START   = 1'b0;
  localparam bit REQ_ARRIVAL = 1'b1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [63:0] COUNT_MAX = 64'd65535;

  typedef struct packed {
    logic        req_type;
    logic [63:0] now_time;
  } req_word_t;

  typedef struct packed {
    logic [63:0] t_start;
    logic [63:0] t_end;
    case_code_t  code;
    logic [15:0] pending;
  } stamp_t;

  // DUT ports
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [29:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;   // [63:0] now_time
  logic [0:0]   in_tuser = '0;   // [0] req_type
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;       // [63:0] start, [127:64] end, [143:128] pending
  logic [2:0]   out_tuser;       // [2:0] case_code

  // predictor state and register copy
  logic [29:0]  buf_len = LEN_RESET;
  logic [63:0]  last_arrival = '0;
  logic [63:0]  last_end = '0;
  logic [15:0]  group_left = '0;
  logic         last_grouped = 1'b0;

  // stimulus and scoreboard
  req_word_t    pending_words[$];
  stamp_t       expected_stamps[$];
  req_word_t    cur_word;
  stamp_t       pred_stamp;
  stamp_t       exp_stamp;
  logic [63:0]  tcur = '0;
  int           words_queued = 0;
  int           words_accepted = 0;
  int           results_seen = 0;
  int           failures = 0;
  int           cycle_count = 0;
  logic         in_taken = 1'b0;
  int           tx_hold = 0;
  int           rx_hold = 0;
  logic         rx_long_done = 1'b0;
  logic         tx_gaps_on = 1'b1;
  logic         rx_stall_on = 1'b1;

  buffer_timestamp_recovery dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Timestamp predictor: advances its state by one word, returns 1 when a result is due
  function automatic bit recover_timestamps(input req_word_t w, output stamp_t s);
    logic [63:0] len;
    logic [63:0] delta;
    logic [63:0] ratio;
    logic [63:0] rem;
    logic [63:0] t_start;
    logic [63:0] t_end;
    case_code_t  code;
    s = '0;
    if (w.req_type == REQ_START) begin
      last_arrival = w.now_time;
      last_end = w.now_time;
      group_left = '0;
      last_grouped = 1'b0;
      return 1'b0;
    end
    // zero length counts as one
    len = (buf_len == '0) ? 64'd1 : {34'd0, buf_len};
    delta = w.now_time - last_arrival;
    ratio = delta / len;
    rem = delta % len;
    if ((rem << 1) >= len)
      ratio = ratio + 64'd1;
    if (ratio > COUNT_MAX)
      ratio = COUNT_MAX;

    if (ratio == 64'd1) begin
      t_start = last_arrival;
      t_end = w.now_time;
      code = CASE_NORMAL;
    end else if (ratio == 64'd0 && group_left != '0) begin
      t_start = w.now_time - {48'd0, group_left} * len;
      t_end = t_start + len;
      if (t_end > w.now_time)
        t_end = w.now_time;
      group_left = group_left - 16'd1;
      last_grouped = 1'b1;
      code = CASE_GROUPED;
    end else if (ratio >= 64'd2) begin
      if (group_left == '0 || last_grouped) begin
        t_start = w.now_time - ratio * len;
        t_end = t_start + len;
        group_left = 16'(ratio - 64'd1);
        last_grouped = 1'b0;
        code = CASE_FIRST;
      end else begin
        t_start = last_end + len;
        t_end = t_start + len;
        if (t_end > w.now_time)
          t_end = w.now_time;
        group_left = group_left - 16'd1;
        code = CASE_DELAYED;
      end
    end else begin
      t_end = w.now_time;
      t_start = w.now_time - len;
      if (t_start < last_end)
        t_start = last_end;
      last_grouped = 1'b0;
      code = CASE_AFTER;
    end
    last_end = t_end;
    last_arrival = w.now_time;
    s.t_start = t_start;
    s.t_end = t_end;
    s.code = code;
    s.pending = group_left;
    return 1'b1;
  endfunction

  // Gap length: half none, some short, a few long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      return 0;
    else if (pick < 85)
      return $urandom_range(1, 3);
    else if (pick < 97)
      return $urandom_range(4, 15);
    else
      return $urandom_range(40, 150);
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      failures++;
    end
  endtask

  task automatic queue_word(input logic req, input logic [63:0] t);
    req_word_t w;
    w.req_type = req;
    w.now_time = t;
    pending_words.push_back(w);
    words_queued++;
    tcur = t;
  endtask

  // Mixed start and arrival streams, arrival deltas mostly near multiples of the buffer length
  task automatic queue_phase(input int count, input logic [29:0] cfg_len);
    logic [63:0] span;
    logic [63:0] delta;
    logic [63:0] k;
    int          pick;
    span = (cfg_len == '0) ? 64'd1 : {34'd0, cfg_len};
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0: begin
          if ($urandom_range(0, 1) == 0)
            queue_word(REQ_START, {$urandom, $urandom});
          else
            queue_word(REQ_START, tcur + 64'($urandom_range(0, 1000)));
        end
        1: queue_word(REQ_ARRIVAL, {$urandom, $urandom});
        2, 3, 4, 5, 18, 19: begin
          // inside half a buffer: grouped or after delay
          delta = 64'($urandom_range(0, 32'((span - 1) / 2)));
          queue_word(REQ_ARRIVAL, tcur + delta);
        end
        6, 7, 8, 9, 10: begin
          // about one buffer: normal
          delta = (span + 1) / 2 + 64'($urandom_range(0, 32'(span - 1)));
          queue_word(REQ_ARRIVAL, tcur + delta);
        end
        11, 12, 13, 14: begin
          k = 64'($urandom_range(2, 6));
          delta = k * span + 64'($urandom_range(0, 32'(span - 1))) - (span - 1) / 2;
          queue_word(REQ_ARRIVAL, tcur + delta);
        end
        15: begin
          // long silence, may saturate the count
          k = 64'($urandom_range(2, 70000));
          queue_word(REQ_ARRIVAL, tcur + k * span);
        end
        default: begin
          // right on a rounding boundary
          k = 64'($urandom_range(0, 3));
          delta = k * span + (span + 1) / 2 - 64'($urandom_range(0, 1));
          queue_word(REQ_ARRIVAL, tcur + delta);
        end
      endcase
    end
  endtask

  task automatic write_buf_len(input logic [29:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    buf_len = v;
  endtask

  // Idle means every queued word taken and every result seen, plus the block's latency
  task automatic wait_drained();
    while (words_accepted != words_queued || expected_stamps.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Sender: presents the next word at the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (tx_hold != 0) begin
        tx_hold <= tx_hold - 1;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        in_tdata <= cur_word.now_time;
        in_tuser <= cur_word.req_type;
        in_tvalid <= 1'b1;
        tx_hold <= tx_gaps_on ? idle_len() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken <= 1'b0;
  end

  // Receiver: one long hold-off once, otherwise random stalls
  always @(negedge clk) begin
    if (!rx_long_done && results_seen >= 60) begin
      rx_long_done <= 1'b1;
      rx_hold <= 900;
      out_tready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
      rx_hold <= idle_len();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Accepted words feed the predictor; accepted results are checked in order
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      words_accepted++;
      in_taken <= 1'b1;
      if (recover_timestamps(cur_word, pred_stamp))
        expected_stamps.push_back(pred_stamp);
    end
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_stamps.size() == 0) begin
        $error("unexpected result word: tdata %h tuser %h", out_tdata, out_tuser);
        failures++;
      end else begin
        exp_stamp = expected_stamps.pop_front();
        check_field("buffer_start_time", exp_stamp.t_start, out_tdata[63:0]);
        check_field("buffer_end_time", exp_stamp.t_end, out_tdata[127:64]);
        check_field("case_code", 64'(exp_stamp.code), 64'(out_tuser));
        check_field("pending_in_group", 64'(exp_stamp.pending), 64'(out_tdata[143:128]));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0] span;
    logic [29:0] lens[6];
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset length, every case, rounding edges, wrap and saturation
    span = 64'(LEN_RESET);
    queue_word(REQ_ARRIVAL, 64'd0);                 // arrival before any start
    queue_word(REQ_ARRIVAL, '1);                    // ratio saturates
    queue_word(REQ_START, '1 - span / 2);
    queue_word(REQ_ARRIVAL, tcur + span);           // normal, wraps past zero
    queue_word(REQ_ARRIVAL, tcur + 3 * span);       // first of group
    queue_word(REQ_ARRIVAL, tcur + 2 * span);       // delayed grouped
    queue_word(REQ_ARRIVAL, tcur + 64'd100);        // grouped
    queue_word(REQ_ARRIVAL, tcur + 64'd5);          // after delay
    queue_word(REQ_ARRIVAL, tcur + (span + 1) / 2); // half rounds up
    queue_word(REQ_ARRIVAL, tcur + (span - 1) / 2); // just below half
    queue_word(REQ_ARRIVAL, tcur + 4 * span);
    queue_word(REQ_ARRIVAL, tcur + 64'd10);
    queue_word(REQ_ARRIVAL, tcur + 2 * span);       // new group right after grouped
    queue_word(REQ_START, 64'd0);
    queue_word(REQ_ARRIVAL, span);
    queue_word(REQ_START, {$urandom, $urandom});
    queue_word(REQ_ARRIVAL, tcur + 64'd1);
    queue_phase(95, LEN_RESET);
    wait_drained();

    // register sweep: minimum, zero, maximum, random small and wide, reset value
    lens[0] = 30'd1;
    lens[1] = 30'd0;
    lens[2] = 30'h3FFF_FFFF;
    lens[3] = 30'($urandom_range(2, 5000));
    lens[4] = 30'($urandom_range(1, 32'h3FFF_FFFF));
    lens[5] = LEN_RESET;
    for (int p = 0; p < 6; p++) begin
      write_buf_len(lens[p]);
      tx_gaps_on = (p % 3) != 1;
      rx_stall_on = (p % 3) != 2 && p != 1;
      @(posedge clk);
      queue_phase(92, lens[p]);
      wait_drained();
    end

    if (failures == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
